// ===== hdl/tsfct_pkg.sv =====
`default_nettype none
package tsfct_pkg;

   localparam int ADC_BITS  = 12;
   localparam int FRAC_BITS = 16;
   localparam int CODE_W    = ADC_BITS;
   // divider width; also the number of restoring steps per division
   localparam int DIV_W     = 28;

   typedef struct packed {
      logic [CODE_W-1:0] code_left;
      logic [CODE_W-1:0] code_right;
      logic [CODE_W-1:0] code_top;
   } req_type;

   typedef struct packed {
      logic [14:0] force_left;
      logic [14:0] force_right;
      logic [14:0] force_top;
      logic [16:0] force_total;
      logic        arm_rested;
      logic [10:0] cop_x;
      logic [12:0] cop_y;
      logic        in_deadzone;
      logic        zone_changed;
   } rsp_type;

   localparam logic [2:0] REG_REST_LEFT  = 3'd0;
   localparam logic [2:0] REG_REST_RIGHT = 3'd1;
   localparam logic [2:0] REG_REST_TOP   = 3'd2;
   localparam logic [2:0] REG_ALPHA      = 3'd3;
   localparam logic [2:0] REG_THRESHOLD  = 3'd4;
   localparam logic [2:0] REG_RADIUS     = 3'd5;

   localparam logic [15:0] ALPHA_RESET     = 16'd9830;
   localparam logic [16:0] THRESHOLD_RESET = 17'd896;
   localparam logic [12:0] RADIUS_RESET    = 13'd512;

   localparam logic [63:0] VREF_Q32 = 64'd14173392077;
   localparam logic [20:0] P1ABS    = 21'd140228;
   localparam logic [20:0] P2       = 21'd1243124;
   localparam logic [20:0] P3ABS    = 21'd1678392;
   localparam logic [14:0] FORCE_MAX = 15'd32767;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_SEED,
      OP_EMA,
      OP_VOLT,
      OP_SQUARE,
      OP_RAW,
      OP_FORCE,
      OP_TOTAL,
      OP_DIV_X_START,
      OP_DIV_STEP,
      OP_DIV_X_END,
      OP_DIV_Y_START,
      OP_DIV_Y_END,
      OP_ZONE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic rested;
   } status_type;

   function automatic logic [18:0] gain_of(input logic [1:0] ch);
      logic [18:0] g;
      case (ch)
         2'd0:    g = 19'd387318;
         2'd1:    g = 19'd342627;
         default: g = 19'd274948;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/tsfct_ctrl.sv =====
`default_nettype none
module tsfct_ctrl
   import tsfct_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       out_free,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_SEED   = 13'b0000000000010,
      ST_EMA    = 13'b0000000000100,
      ST_VOLT   = 13'b0000000001000,
      ST_SQUARE = 13'b0000000010000,
      ST_RAW    = 13'b0000000100000,
      ST_FORCE  = 13'b0000001000000,
      ST_TOTAL  = 13'b0000010000000,
      ST_DIVX   = 13'b0000100000000,
      ST_DIVY   = 13'b0001000000000,
      ST_ZONE   = 13'b0010000000000,
      ST_FINISH = 13'b0100000000000,
      ST_DIVI   = 13'b1000000000000
   } state_type;

   localparam int DivSteps = DIV_W;
   localparam int CntW = $clog2(DivSteps + 1);

   state_type     state_ff, state_in;
   logic [1:0]    ch_ff, ch_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic          ydiv_ff, ydiv_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      ydiv_in  = ydiv_ff;
      cmd.op   = OP_NONE;
      cmd.ch   = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.op = OP_SEED;
            ch_in = 2'd0;
            state_in = ST_EMA;
         end
         ST_EMA: begin
            cmd.op = OP_EMA;
            state_in = ST_VOLT;
         end
         ST_VOLT: begin
            cmd.op = OP_VOLT;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op = OP_SQUARE;
            state_in = ST_RAW;
         end
         ST_RAW: begin
            cmd.op = OP_RAW;
            state_in = ST_FORCE;
         end
         ST_FORCE: begin
            cmd.op = OP_FORCE;
            if (ch_ff == 2'd2) begin
               state_in = ST_TOTAL;
            end else begin
               ch_in = ch_ff + 2'd1;
               state_in = ST_EMA;
            end
         end
         ST_TOTAL: begin
            cmd.op = OP_TOTAL;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            // skip the divider when not rested
            if (!status.rested) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op = OP_DIV_X_START;
               cnt_in = '0;
               ydiv_in = 1'b0;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (cnt_ff == CntW'(DivSteps)) begin
               cmd.op = OP_DIV_X_END;
               cnt_in = '0;
               state_in = ST_DIVY;
            end else begin
               cmd.op = OP_DIV_STEP;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIVY: begin
            if (!ydiv_ff) begin
               cmd.op = OP_DIV_Y_START;
               ydiv_in = 1'b1;
            end else if (cnt_ff == CntW'(DivSteps)) begin
               cmd.op = OP_DIV_Y_END;
               state_in = ST_ZONE;
            end else begin
               cmd.op = OP_DIV_STEP;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ZONE: begin
            cmd.op = OP_ZONE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
         cnt_ff   <= '0;
         ydiv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
         ydiv_ff  <= ydiv_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> state_ff == ST_SEED)
      else $error("start lost");
   a_ch_range: assert property (@(posedge clock) disable iff (reset) ch_ff != 2'd3)
      else $error("channel out of range");

endmodule
`default_nettype wire

// ===== hdl/tsfct_dp.sv =====
`default_nettype none
module tsfct_dp
   import tsfct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  req_type          req_data,
   input  cmd_type          cmd,
   input  wire logic [11:0] rest_left,
   input  wire logic [11:0] rest_right,
   input  wire logic [11:0] rest_top,
   input  wire logic [15:0] alpha,
   input  wire logic [16:0] threshold,
   input  wire logic [12:0] radius,
   output status_type       status,
   output rsp_type          result,
   output logic             result_load
);

   localparam int AdcBits = ADC_BITS;
   localparam int FracBits = FRAC_BITS;
   localparam int SW = AdcBits + FracBits;
   localparam logic [63:0] AdcMax = (64'd1 << AdcBits) - 64'd1;
   localparam logic [35:0] VoltPerCode = 36'((VREF_Q32 + AdcMax / 64'd2) / AdcMax);
   localparam int VShift = FracBits + 16;
   localparam int DW = DIV_W;

   logic [AdcBits-1:0] code_ff [3];
   logic [SW-1:0]      smooth_ff [3];
   logic               seeded_ff, seeded_in;
   logic               inside_was_ff, inside_was_in;
   logic [18:0]        v_ff;
   logic [37:0]        vsq_ff;
   logic [40:0]        raw_ff;
   logic [14:0]        force_ff [3];
   logic [16:0]        total_ff;
   logic               rested_ff;
   logic [DW-1:0]      rem_ff;
   logic [DW-1:0]      num_ff;
   logic [DW-1:0]      quo_ff;
   logic [10:0]        cx_ff;
   logic [12:0]        cy_ff;
   logic               inside_ff, changed_ff;

   logic [11:0]   rest_sel;
   logic [SW-1:0] s_cur;
   logic [SW-1:0] rest_sh;
   logic [SW+16:0] ema_sum;
   logic [SW+36:0] vprod;
   logic [40:0]   pos, neg;
   logic [60:0]   fprod;
   logic [19:0]   fval;
   logic [DW:0]   trial;
   logic [DW-1:0] half;
   logic signed [15:0] dx, dy;
   logic [33:0]   dist_sq, lim;

   assign status.rested = rested_ff;

   always_comb begin
      case (cmd.ch)
         2'd0:    rest_sel = rest_left;
         2'd1:    rest_sel = rest_right;
         default: rest_sel = rest_top;
      endcase
   end

   assign s_cur   = smooth_ff[cmd.ch];
   assign rest_sh = SW'(rest_sel[AdcBits-1:0]) << FracBits;
   assign ema_sum = (SW+17)'({code_ff[cmd.ch], {FracBits{1'b0}}}) * alpha
                  + (SW+17)'(s_cur) * (17'h10000 - 17'(alpha)) + (SW+17)'(32768);
   assign vprod   = (SW+37)'(s_cur) * VoltPerCode + ((SW+37)'(1) << (VShift - 1));
   assign pos     = 41'(P2) * 41'(v_ff);
   assign neg     = 41'((vsq_ff * 38'(P1ABS) + 59'd32768) >> 16) + (41'(P3ABS) << 16);
   assign fprod   = 61'(raw_ff) * 61'(gain_of(cmd.ch)) + (61'd1 << 39);
   assign fval    = 20'(fprod >> 40);
   assign trial   = {rem_ff, num_ff[DW-1]} - (DW+1)'(total_ff);
   assign half    = DW'(total_ff >> 1);
   assign dx      = 16'(3 * $signed({5'd0, cx_ff})) - 16'sd1792;
   assign dy      = 16'(3 * $signed({3'd0, cy_ff})) - 16'sd5632;
   assign dist_sq = $unsigned(34'(dx) * 34'(dx)) + $unsigned(34'(dy) * 34'(dy));
   assign lim     = 34'(9) * 34'(radius) * 34'(radius);

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff[0] <= req_data.code_left[AdcBits-1:0];
         code_ff[1] <= req_data.code_right[AdcBits-1:0];
         code_ff[2] <= req_data.code_top[AdcBits-1:0];
      end
      case (cmd.op)
         OP_VOLT:   v_ff <= 19'(vprod >> VShift);
         OP_SQUARE: vsq_ff <= 38'(v_ff) * 38'(v_ff);
         OP_RAW:    raw_ff <= (pos > neg) ? pos - neg : '0;
         OP_FORCE: begin
            if (s_cur <= rest_sh) begin
               force_ff[cmd.ch] <= '0;
            end else begin
               force_ff[cmd.ch] <= (fval > 20'(FORCE_MAX)) ? FORCE_MAX : fval[14:0];
            end
         end
         OP_TOTAL: begin
            total_ff  <= 17'(force_ff[0]) + 17'(force_ff[1]) + 17'(force_ff[2]);
            rested_ff <= (17'(force_ff[0]) + 17'(force_ff[1]) + 17'(force_ff[2]))
                         > threshold;
            cx_ff <= '0;
            cy_ff <= '0;
            inside_ff <= 1'b0;
            changed_ff <= 1'b0;
         end
         OP_DIV_X_START: begin
            num_ff <= DW'(1792) * DW'(force_ff[1]) + DW'(896) * DW'(force_ff[2]) + half;
            rem_ff <= '0;
         end
         OP_DIV_Y_START: begin
            num_ff <= DW'(5632) * DW'(force_ff[2]) + half;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            // one restoring step per cycle
            if (!trial[DW]) begin
               rem_ff <= trial[DW-1:0];
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]};
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            num_ff <= {num_ff[DW-2:0], 1'b0};
         end
         OP_DIV_X_END: cx_ff <= quo_ff[10:0];
         OP_DIV_Y_END: cy_ff <= quo_ff[12:0];
         OP_ZONE: begin
            inside_ff  <= dist_sq <= lim;
            changed_ff <= (dist_sq <= lim) != inside_was_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      seeded_in     = seeded_ff;
      inside_was_in = inside_was_ff;
      if (cmd.op == OP_SEED) begin
         seeded_in = 1'b1;
      end
      if (cmd.op == OP_ZONE) begin
         inside_was_in = dist_sq <= lim;
      end
      if (cmd.op == OP_FINISH && !rested_ff) begin
         inside_was_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff     <= 1'b0;
         inside_was_ff <= 1'b0;
         for (int i = 0; i < 3; i++) smooth_ff[i] <= '0;
      end else begin
         seeded_ff     <= seeded_in;
         inside_was_ff <= inside_was_in;
         if (cmd.op == OP_SEED && !seeded_ff) begin
            smooth_ff[0] <= SW'(rest_left[AdcBits-1:0]) << FracBits;
            smooth_ff[1] <= SW'(rest_right[AdcBits-1:0]) << FracBits;
            smooth_ff[2] <= SW'(rest_top[AdcBits-1:0]) << FracBits;
         end
         if (cmd.op == OP_EMA) begin
            smooth_ff[cmd.ch] <= SW'(ema_sum >> 16);
         end
      end
   end

   assign result_load        = (cmd.op == OP_FINISH);
   assign result.force_left  = force_ff[0];
   assign result.force_right = force_ff[1];
   assign result.force_top   = force_ff[2];
   assign result.force_total = total_ff;
   assign result.arm_rested  = rested_ff;
   assign result.cop_x       = cx_ff;
   assign result.cop_y       = cy_ff;
   assign result.in_deadzone = inside_ff;
   assign result.zone_changed = changed_ff;

   a_zone_rested: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ZONE) |-> rested_ff)
      else $error("zone test while not rested");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_X_START) |-> total_ff != '0)
      else $error("divide by zero");
   a_seed_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMA) |-> seeded_ff)
      else $error("filter used before seeding");

endmodule
`default_nettype wire

// ===== hdl/three_sensor_force_cop_tracker_unit.sv =====
`default_nettype none
// Three-sensor force and centre-of-pressure tracker.
// Input channel req_*: one item holds three ADC codes; accepted when
// req_valid is high and req_stall is low. Result channel rsp_*: one item per
// input item, held while rsp_stall is high.
// Registers are written over the csr_ APB port at byte address 4*index;
// the user must write them only while the block is idle; it does not enforce this.
// Each item runs through one shared controller: per channel the filter,
// volts, square, raw value and force steps, then the total, and when
// the arm is rested two 28-step serial divisions for the pressure centre
// and a dead-zone compare. One item is in work at a time; the next item
// can be taken in the cycle after the result is loaded, even if the result
// waits in the output register.
// Reset clears the filters, the seeded flag and the zone history and loads
// register defaults. The first item seeds the filters with the rest levels.
// While the output register holds an item and rsp_stall is high, a finished
// item waits in the work registers until the output register frees.
module three_sensor_force_cop_tracker_unit
   import tsfct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [11:0] rest_left_ff, rest_right_ff, rest_top_ff;
   logic [15:0] alpha_ff;
   logic [16:0] threshold_ff;
   logic [12:0] radius_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   cmd_type     cmd;
   status_type  status;
   rsp_type     result;
   logic        result_load, busy, start, out_free;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign start = req_valid && !busy;
   assign req_stall = busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_left_ff  <= '0;
         rest_right_ff <= '0;
         rest_top_ff   <= '0;
         alpha_ff      <= ALPHA_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         radius_ff     <= RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_REST_LEFT:  rest_left_ff  <= csr_pwdata[11:0];
            REG_REST_RIGHT: rest_right_ff <= csr_pwdata[11:0];
            REG_REST_TOP:   rest_top_ff   <= csr_pwdata[11:0];
            REG_ALPHA:      alpha_ff      <= csr_pwdata[15:0];
            REG_THRESHOLD:  threshold_ff  <= csr_pwdata[16:0];
            REG_RADIUS:     radius_ff     <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_REST_LEFT:  csr_prdata = 32'(rest_left_ff);
         REG_REST_RIGHT: csr_prdata = 32'(rest_right_ff);
         REG_REST_TOP:   csr_prdata = 32'(rest_top_ff);
         REG_ALPHA:      csr_prdata = 32'(alpha_ff);
         REG_THRESHOLD:  csr_prdata = 32'(threshold_ff);
         REG_RADIUS:     csr_prdata = 32'(radius_ff);
         default:        csr_prdata = '0;
      endcase
   end

   tsfct_ctrl u_ctrl (
      .clock, .reset, .start, .out_free, .status, .cmd, .busy
   );

   tsfct_dp u_dp (
      .clock, .reset, .load(start), .req_data, .cmd,
      .rest_left(rest_left_ff), .rest_right(rest_right_ff), .rest_top(rest_top_ff),
      .alpha(alpha_ff), .threshold(threshold_ff), .radius(radius_ff),
      .status, .result, .result_load
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_load |-> out_free)
      else $error("result overwritten");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("accepted while busy");
   a_rested_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.arm_rested) |-> (rsp_data.cop_x == '0 && !rsp_data.zone_changed))
      else $error("centre set while not rested");

endmodule
`default_nettype wire
